@@ design/rbe_pkg.sv @@
package rbe_pkg;

    localparam int STATE_W     = 24;
    localparam int FREQ_W      = 11;
    localparam int START_W     = 10;
    localparam int TOTAL_BITS  = 10;
    localparam int RENORM_BITS = 14;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [STATE_W-1:0] LOW_BOUND = 24'd65536;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_opcode;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd_kind;

    // one queued job for the coding engine
    typedef struct packed {
        t_cmd_kind           kind;
        logic [FREQ_W-1:0]   freq;
        logic [START_W-1:0]  start;
    } t_cmd;

endpackage

@@ design/rbe_front.sv @@
module rbe_front #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_opcode,
    input  logic [7:0]          i_symbol_index,
    input  logic [10:0]         i_table_frequency,
    output logic                o_push,
    output rbe_pkg::t_cmd       o_cmd,
    input  logic                i_full
);
    import rbe_pkg::*;

    localparam int DEPTH = (ALPHABET_SIZE < 256) ? ALPHABET_SIZE : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FREQ_W-1:0]  r_mem_freq  [DEPTH];
    logic [START_W-1:0] r_mem_start [DEPTH];

    logic               r_pend;
    t_cmd_kind          r_pend_kind;
    logic               r_pend_in_range;
    logic [FREQ_W-1:0]  r_rd_freq;
    logic [START_W-1:0] r_rd_start;
    logic [FREQ_W-1:0]  r_run_sum;

    logic               accept;
    logic               in_range;
    logic [AW-1:0]      addr;
    logic [FREQ_W-1:0]  base_sum;
    t_opcode            op;

    assign op       = t_opcode'(i_opcode);
    assign accept   = i_valid && o_ready;
    assign in_range = ({24'd0, i_symbol_index} < 32'(ALPHABET_SIZE));
    assign addr     = i_symbol_index[AW-1:0];
    // running sum restarts at index 0
    assign base_sum = (i_symbol_index == 8'd0) ? '0 : r_run_sum;

    assign o_ready = !r_pend;
    assign o_push  = r_pend && !i_full;

    always_comb begin
        o_cmd.kind  = r_pend_kind;
        o_cmd.freq  = (r_pend_kind == CMD_ENCODE && r_pend_in_range) ? r_rd_freq : '0;
        o_cmd.start = r_rd_start;
    end

    // table write and registered read, held while the job waits for the queue
    always_ff @(posedge i_clk) begin
        if (accept && op == OP_LOAD && in_range) begin
            r_mem_freq[addr]  <= i_table_frequency;
            r_mem_start[addr] <= base_sum[START_W-1:0];
        end
        if (accept) begin
            r_rd_freq  <= r_mem_freq[addr];
            r_rd_start <= r_mem_start[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_run_sum <= '0;
        end else begin
            if (o_push) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                unique case (op)
                    OP_LOAD: begin
                        if (in_range) begin
                            r_run_sum <= base_sum + i_table_frequency;
                        end
                    end
                    OP_ENCODE: begin
                        r_pend <= 1'b1;
                    end
                    OP_FLUSH: begin
                        r_pend <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_kind     <= (op == OP_FLUSH) ? CMD_FLUSH : CMD_ENCODE;
            r_pend_in_range <= in_range;
        end
    end

endmodule

@@ design/rbe_fifo.sv @@
module rbe_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbe_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rbe_pkg::t_cmd o_cmd
);
    import rbe_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/rbe_back.sv @@
module rbe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  rbe_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    output logic          o_error_flag
);
    import rbe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RENORM,
        S_DIV,
        S_UPDATE,
        S_FLUSH,
        S_ERR
    } t_state;

    localparam int LIM_W = FREQ_W + RENORM_BITS;

    t_state             r_state;
    logic [STATE_W-1:0] r_x;
    logic [FREQ_W-1:0]  r_freq;
    logic [START_W-1:0] r_start;
    logic [FREQ_W-1:0]  r_rem;
    logic [4:0]         r_cnt;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_err;

    logic               slot_free;
    logic [LIM_W-1:0]   limit;
    logic               emit_now;
    logic               more_after;
    logic [FREQ_W:0]    rem_sh;
    logic               q_bit;
    logic [FREQ_W:0]    rem_diff;

    assign slot_free  = !r_out_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign limit      = {r_freq, {RENORM_BITS{1'b0}}};
    assign emit_now   = (LIM_W'(r_x) >= limit);
    assign more_after = (LIM_W'(r_x >> 8) >= limit);

    // one restoring division step per cycle
    assign rem_sh   = {r_rem, r_x[STATE_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_freq});
    assign rem_diff = rem_sh - {1'b0, r_freq};

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_error_flag  = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= LOW_BOUND;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_freq  <= i_cmd.freq;
                        r_start <= i_cmd.start;
                        r_cnt   <= '0;
                        if (i_cmd.kind == CMD_FLUSH) begin
                            r_state <= S_FLUSH;
                        end else if (i_cmd.freq == '0) begin
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_RENORM;
                        end
                    end
                end
                S_RENORM: begin
                    if (!emit_now) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_x[7:0];
                        r_out_last  <= !more_after;
                        r_out_err   <= 1'b0;
                        r_x         <= r_x >> 8;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? rem_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
                    r_x   <= {r_x[STATE_W-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(STATE_W - 1)) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_x <= {r_x[STATE_W-TOTAL_BITS-1:0], {TOTAL_BITS{1'b0}}}
                         + STATE_W'(r_start) + STATE_W'(r_rem);
                    r_state <= S_IDLE;
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_x[7:0];
                        r_out_last  <= (r_cnt[1:0] == 2'd3);
                        r_out_err   <= 1'b0;
                        r_cnt       <= r_cnt + 1'b1;
                        if (r_cnt[1:0] == 2'd3) begin
                            r_x     <= LOW_BOUND;
                            r_state <= S_IDLE;
                        end else begin
                            r_x <= r_x >> 8;
                        end
                    end
                end
                S_ERR: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= 8'd0;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/rans_byte_encoder.sv @@
// channel | signals                                              | direction
// in      | i_valid, o_ready, i_opcode, i_symbol_index,          | input items
//         | i_table_frequency                                    |
// out     | o_valid, i_ready, o_out_byte, o_last_of_run,         | stream bytes
//         | o_error_flag                                         |
//
// a load writes the table; an encode or flush reads it first into a job held for the queue
// encode: the pop, renormalisation with one byte out per step, then the radix-2 divider
// over every state bit, and the update
// flush: the pop, then four state bytes low first; zero-frequency symbol: one error byte
// synchronous active-low reset sets the state to 65536; the table is not cleared
// a stalled output holds the engine; the front takes items until the four-entry queue fills
module rans_byte_encoder #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_symbol_index,
    input  logic [10:0] i_table_frequency,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_error_flag
);
    import rbe_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    rbe_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_symbol_index    (i_symbol_index),
        .i_table_frequency (i_table_frequency),
        .o_push            (push),
        .o_cmd             (push_cmd),
        .i_full            (full)
    );

    rbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    rbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_error_flag  (o_error_flag)
    );

endmodule

@@ design/rbe_checker.sv @@
module rbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_opcode,
    input logic [7:0]  i_symbol_index,
    input logic [10:0] i_table_frequency,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run,
    input logic        o_error_flag
);
    import rbe_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_error_flag))
        else $error("result changed while stalled");

    // an error result is a single zero byte closing its run
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_flag |-> o_out_byte == 8'd0 && o_last_of_run)
        else $error("malformed error result");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // an encode or flush is held for the table read before the next item
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready
            && (i_opcode == OP_ENCODE || i_opcode == OP_FLUSH) |=> !o_ready)
        else $error("front took an item while a job was pending");

endmodule

bind rans_byte_encoder rbe_checker u_rbe_checker (.*);

@@ test/tb_rans_byte_encoder.sv @@
module tb_rans_byte_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rbe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_WAIT = 13;
    localparam int ITEM_TARGET = 210;
    localparam int TAIL_CYCLES = 200;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct {
        logic [1:0]        op;
        logic [7:0]        idx;
        logic [FREQ_W-1:0] freq;
        int                gap;
        bit                drain;
    } t_coder_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_stream_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = 2'd0;
    logic [7:0]  i_symbol_index = 8'd0;
    logic [10:0] i_table_frequency = 11'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        o_error_flag;

    rans_byte_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_symbol_index    (i_symbol_index),
        .i_table_frequency (i_table_frequency),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_byte        (o_out_byte),
        .o_last_of_run     (o_last_of_run),
        .o_error_flag      (o_error_flag)
    );

    // stimulus generation
    t_coder_item item_q[$];
    bit          gen_written[256];
    int          cur_table[$];
    int          gen_calm = 0;
    int          gen_count = 0;
    int          total_items = 0;

    // coder model
    logic [STATE_W-1:0] enc_state = LOW_BOUND;
    logic [FREQ_W-1:0]  enc_freq[256];
    logic [START_W-1:0] enc_start[256];
    logic [FREQ_W-1:0]  enc_sum = '0;
    t_stream_byte       byte_expect_q[$];

    int pred_count = 0;
    int rcv_count = 0;
    int sent_count = 0;
    int fail_count = 0;
    int flush_count = 0;
    int err_seen = 0;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic add_item(input logic [1:0] op, input int idx, input int freq,
                            input bit drain);
        t_coder_item it;
        it.op = op;
        it.idx = idx[7:0];
        it.freq = freq[FREQ_W-1:0];
        it.drain = drain;
        if (gen_calm > 0) begin
            it.gap = 0;
            gen_calm--;
        end else begin
            it.gap = $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 15) == 0) gen_calm = $urandom_range(8, 24);
        end
        if (op == OP_LOAD) gen_written[idx[7:0]] = 1'b1;
        if (op != OP_UNUSED) gen_count++;
        item_q.push_back(it);
    endtask

    task automatic push_expect(input logic [7:0] data, input logic last, input logic err);
        byte_expect_q.push_back('{data, last, err});
        pred_count++;
    endtask

    // bytes the coder emits for one accepted item, and its new state
    task automatic predict_bytes(input t_coder_item it);
        logic [31:0]     x, nx, lim, q, r, f, s;
        logic [FREQ_W:0] acc;
        int              n;
        case (it.op)
            OP_LOAD: begin
                acc = (it.idx == 8'd0) ? '0 : {1'b0, enc_sum};
                enc_freq[it.idx] = it.freq;
                enc_start[it.idx] = acc[START_W-1:0];
                acc = acc + it.freq;
                enc_sum = acc[FREQ_W-1:0];
            end
            OP_ENCODE: begin
                x = 32'(enc_state);
                f = 32'(enc_freq[it.idx]);
                s = 32'(enc_start[it.idx]);
                if (f == 0) begin
                    push_expect(8'd0, 1'b1, 1'b1);
                end else begin
                    lim = f << RENORM_BITS;
                    n = 0;
                    while (x >= lim && n < 4) begin
                        nx = x >> 8;
                        push_expect(x[7:0], !(nx >= lim && n < 3), 1'b0);
                        x = nx;
                        n++;
                    end
                    q = x / f;
                    r = x % f;
                    x = (q << TOTAL_BITS) + s + r;
                    enc_state = x[STATE_W-1:0];
                end
            end
            OP_FLUSH: begin
                for (int i = 0; i < 4; i++) begin
                    push_expect(enc_state[8*i +: 8], i == 3, 1'b0);
                end
                enc_state = LOW_BOUND;
                flush_count++;
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // sender
    t_coder_item cur;
    bit          have_cur = 1'b0;
    int          gap_left = 0;
    logic        nxt_valid;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            have_cur = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_bytes(cur);
                sent_count++;
                have_cur = 1'b0;
            end
            if (!i_valid || o_ready) begin
                if (!have_cur && item_q.size() > 0) begin
                    cur = item_q.pop_front();
                    have_cur = 1'b1;
                    gap_left = cur.gap;
                end
                nxt_valid = 1'b0;
                if (have_cur) begin
                    if (cur.drain && pred_count != rcv_count) begin
                        // hold off until the stream has drained
                    end else if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        nxt_valid = 1'b1;
                    end
                end
                i_valid <= nxt_valid;
                if (nxt_valid) begin
                    i_opcode <= cur.op;
                    i_symbol_index <= cur.idx;
                    i_table_frequency <= cur.freq;
                end
            end
        end
    end

    // receiver
    int           stall_left = 0;
    int           rx_calm = 0;
    t_stream_byte want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
            rx_calm = 0;
        end else begin
            if (o_valid && i_ready) begin
                rcv_count <= rcv_count + 1;
                if (o_error_flag === 1'b1) err_seen++;
                if (byte_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h last %b err %b",
                                            o_out_byte, o_last_of_run, o_error_flag));
                end else begin
                    want = byte_expect_q.pop_front();
                    if (o_out_byte !== want.data)
                        flag_mismatch($sformatf("byte %02h, want %02h", o_out_byte, want.data));
                    if (o_last_of_run !== want.last)
                        flag_mismatch($sformatf("last_of_run %b, want %b",
                                                o_last_of_run, want.last));
                    if (o_error_flag !== want.err)
                        flag_mismatch($sformatf("error_flag %b, want %b",
                                                o_error_flag, want.err));
                end
                if (rx_calm > 0) begin
                    rx_calm--;
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, MAX_WAIT);
                    if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(8, 24);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        bit picked[256];
        int k, n, left, f, z, waited;

        // directed part
        add_item(OP_FLUSH, 0, 0, 1'b0);
        add_item(OP_LOAD, 0, 1024, 1'b0);
        add_item(OP_ENCODE, 0, 0, 1'b0);
        add_item(OP_ENCODE, 0, 2047, 1'b0);
        add_item(OP_LOAD, 0, 1, 1'b0);
        add_item(OP_LOAD, 255, 1023, 1'b0);
        // frequency one: a byte per encode, then two bytes on the fourth
        repeat (4) add_item(OP_ENCODE, 0, 0, 1'b0);
        add_item(OP_ENCODE, 255, 1, 1'b0);
        add_item(OP_LOAD, 1, 0, 1'b0);
        add_item(OP_ENCODE, 1, 0, 1'b0);
        add_item(OP_UNUSED, 170, 1365, 1'b0);
        add_item(OP_LOAD, 7, 2047, 1'b0);
        add_item(OP_ENCODE, 7, 0, 1'b0);
        add_item(OP_ENCODE, 7, 0, 1'b0);
        add_item(OP_FLUSH, 255, 2047, 1'b1);

        // random part: mostly whole tables followed by encodes and usually a flush
        while (gen_count < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(1, 12);
                picked = '{default: 1'b0};
                picked[0] = 1'b1;
                n = 1;
                while (n < k) begin
                    z = $urandom_range(1, 255);
                    if (!picked[z]) begin
                        picked[z] = 1'b1;
                        n++;
                    end
                end
                cur_table.delete();
                left = 1024;
                n = 0;
                for (int i = 0; i < 256; i++) begin
                    if (picked[i]) begin
                        n++;
                        f = (n == k) ? left : $urandom_range(1, left - (k - n));
                        left -= f;
                        cur_table.push_back(i);
                        add_item(OP_LOAD, i, f, 1'b0);
                    end
                end
                // now and then an unusable symbol among the good ones
                if ($urandom_range(0, 5) == 0) begin
                    z = $urandom_range(1, 255);
                    while (picked[z]) z = $urandom_range(1, 255);
                    cur_table.push_back(z);
                    add_item(OP_LOAD, z, 0, 1'b0);
                end
                repeat ($urandom_range(4, 24)) begin
                    add_item(OP_ENCODE, cur_table[$urandom_range(0, cur_table.size() - 1)],
                             $urandom_range(0, 2047), 1'b0);
                end
                if ($urandom_range(0, 6) != 0)
                    add_item(OP_FLUSH, $urandom_range(0, 255), $urandom_range(0, 2047),
                             $urandom_range(0, 4) == 0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 3))
                        0: add_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 2047),
                                    1'b0);
                        1: begin
                            z = $urandom_range(0, 255);
                            while (!gen_written[z]) z = (z + 1) % 256;
                            add_item(OP_ENCODE, z, $urandom_range(0, 2047), 1'b0);
                        end
                        2: add_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 2047),
                                    1'b0);
                        default: add_item(OP_FLUSH, $urandom_range(0, 255),
                                          $urandom_range(0, 2047), 1'b0);
                    endcase
                end
            end
        end
        add_item(OP_FLUSH, 0, 0, 1'b0);
        total_items = item_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count < total_items) @(negedge i_clk);
        waited = 0;
        while (pred_count != rcv_count && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (byte_expect_q.size() != 0)
            flag_mismatch($sformatf("%0d expected bytes never came", byte_expect_q.size()));

        $display("covered %0d coder items with %0d flushes; %0d stream bytes checked",
                 total_items, flush_count, rcv_count);
        $display("%0d zero-frequency error transfers seen, %0d mismatches", err_seen,
                 fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ rans_byte_encoder.f @@
design/rbe_pkg.sv
design/rbe_front.sv
design/rbe_fifo.sv
design/rbe_back.sv
design/rans_byte_encoder.sv
design/rbe_checker.sv
test/tb_rans_byte_encoder.sv
